FILE: hw/rtl/uafmt_pkg.sv
// ----------------------------------------------------------------------------
// uafmt_pkg
// Shared types, codes and the digit glyph function of the unsigned to ASCII
// formatter.
// ----------------------------------------------------------------------------
package uafmt_pkg;

	localparam logic FUNC_DEC = 1'b0;
	localparam logic FUNC_HEX = 1'b1;

	localparam logic [6:0] ASCII_ZERO = 7'h30;
	localparam logic [6:0] ASCII_UPPER_A = 7'h41;
	localparam logic [3:0] DEC_RADIX = 4'd10;
	localparam logic [3:0] BCD_ADJ_LIMIT = 4'd5;
	localparam logic [3:0] BCD_ADJ = 4'd3;

	typedef struct packed {
		logic func;
		logic [31:0] value;
	} uafmt_req_t;

	typedef struct packed {
		logic [6:0] ascii_char;
		logic last;
	} uafmt_res_t;

	typedef struct packed {
		logic busy;
		logic done;
	} uafmt_dab_stat_t;

	function automatic logic [6:0] uafmt_glyph(input logic [3:0] d);
		logic [6:0] g;
		if (d < DEC_RADIX) begin
			g = ASCII_ZERO + {3'b000, d};
		end else begin
			g = ASCII_UPPER_A + {3'b000, d - DEC_RADIX};
		end
		return g;
	endfunction

endpackage

FILE: hw/rtl/unsigned_to_ascii_formatter_top.sv
// ----------------------------------------------------------------------------
// unsigned_to_ascii_formatter_top
// Unsigned binary to ASCII decimal / upper-case hex text, one character per
// result, leading zeros suppressed, last character flagged.
// ----------------------------------------------------------------------------
// channel   ports                      handshake
// request   start, busy, req           taken when start && !busy
// result    strobe, result             one cycle per character, no stall
//
// Hex: the request loads the digit shifter, which walks one hex digit slot
// (NHEX) per cycle. Decimal: the bit-serial BCD converter takes the
// VALUE_WIDTH bits one per cycle, its done register hands off, then the
// shifter walks the NDEC digit slots. The digit shifter walks every slot,
// suppressed leading zeros included. Results show in the cycle after their
// slot. Reset clears the counters, the flags and the strobe only.
// ----------------------------------------------------------------------------
module unsigned_to_ascii_formatter_top
	import uafmt_pkg::*;
#(
	parameter int VALUE_WIDTH = 32
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  uafmt_req_t req,
	output logic busy,
	output logic strobe,
	output uafmt_res_t result
);

	localparam int NDEC = ((VALUE_WIDTH * 1233) >> 12) + 1;
	localparam int NHEX = (VALUE_WIDTH + 3) / 4;
	localparam int NDIG = (NDEC > NHEX) ? NDEC : NHEX;
	localparam int CW = $clog2(NDIG + 1);
	localparam int DEC_PAD = (NDIG - NDEC) * 4;
	localparam int HEX_PAD = (NDIG - NHEX) * 4;

	logic accept;
	logic [VALUE_WIDTH+31:0] val_wide;
	logic [VALUE_WIDTH-1:0] val_w;
	logic [NHEX*4+VALUE_WIDTH-1:0] hex_wide;
	logic [NDIG*4+NHEX*4-1:0] hex_ext;
	logic [NDIG*4+NDEC*4-1:0] dec_ext;
	logic [NDIG*4-1:0] hex_digits;
	logic [NDIG*4-1:0] dec_digits;
	logic [NDEC*4-1:0] bcd;
	uafmt_dab_stat_t dab_stat;
	logic emit_busy;
	logic emit_load;
	logic [NDIG*4-1:0] load_digits;
	logic [CW-1:0] load_cnt;

	assign accept = start && !busy;

	// keep only the low VALUE_WIDTH bits of the request value
	assign val_wide = {{VALUE_WIDTH{1'b0}}, req.value};
	assign val_w = val_wide[VALUE_WIDTH-1:0];

	assign hex_wide = {{NHEX*4{1'b0}}, val_w};
	assign hex_ext = {{NDIG*4{1'b0}}, hex_wide[NHEX*4-1:0]};
	assign hex_digits = hex_ext[NDIG*4-1:0] << HEX_PAD;
	assign dec_ext = {{NDIG*4{1'b0}}, bcd};
	assign dec_digits = dec_ext[NDIG*4-1:0] << DEC_PAD;

	uafmt_dabble #(
		.VALUE_WIDTH(VALUE_WIDTH),
		.NDEC(NDEC)
	) u_dabble (
		.clk(clk),
		.arst_n(arst_n),
		.go(accept && (req.func == FUNC_DEC)),
		.value(val_w),
		.stat(dab_stat),
		.bcd(bcd)
	);

	assign emit_load = (accept && (req.func == FUNC_HEX)) || dab_stat.done;
	assign load_digits = dab_stat.done ? dec_digits : hex_digits;
	assign load_cnt = dab_stat.done ? CW'(NDEC) : CW'(NHEX);

	uafmt_emit #(
		.NDIG(NDIG)
	) u_emit (
		.clk(clk),
		.arst_n(arst_n),
		.load(emit_load),
		.load_digits(load_digits),
		.load_cnt(load_cnt),
		.busy(emit_busy),
		.strobe(strobe),
		.result(result)
	);

	assign busy = dab_stat.busy | emit_busy;

	a_mid_char_busy: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !result.last |-> busy)
		else $error("non-final character while idle");

	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && result.last |-> !busy)
		else $error("final character while still busy");

	a_no_early_char: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> !strobe)
		else $error("character right after request");

	a_glyph_range: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> ((result.ascii_char >= 7'h30 && result.ascii_char <= 7'h39) ||
			(result.ascii_char >= 7'h41 && result.ascii_char <= 7'h46)))
		else $error("character outside digit set");

endmodule

FILE: hw/rtl/uafmt_dabble.sv
// ----------------------------------------------------------------------------
// uafmt_dabble
// Bit-serial binary to BCD converter (shift and add-3), one value bit per
// cycle, MSB first.
// ----------------------------------------------------------------------------
module uafmt_dabble
	import uafmt_pkg::*;
#(
	parameter int VALUE_WIDTH = 32,
	parameter int NDEC = 10
) (
	input  logic clk,
	input  logic arst_n,
	input  logic go,
	input  logic [VALUE_WIDTH-1:0] value,
	output uafmt_dab_stat_t stat,
	output logic [NDEC*4-1:0] bcd
);

	localparam int BW = $clog2(VALUE_WIDTH + 1);

	logic [BW-1:0] bcnt_q;
	logic done_q;
	logic [VALUE_WIDTH-1:0] val_q;
	logic [NDEC*4-1:0] bcd_q;
	logic [NDEC*4-1:0] adj;

	// every digit cell corrects itself before the shift
	always_comb begin
		for (int i = 0; i < NDEC; i++) begin
			if (bcd_q[i*4 +: 4] >= BCD_ADJ_LIMIT) begin
				adj[i*4 +: 4] = bcd_q[i*4 +: 4] + BCD_ADJ;
			end else begin
				adj[i*4 +: 4] = bcd_q[i*4 +: 4];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bcnt_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= (bcnt_q == BW'(1));
			if (go) begin
				bcnt_q <= BW'(VALUE_WIDTH);
			end else if (bcnt_q != '0) begin
				bcnt_q <= bcnt_q - BW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			val_q <= value;
			bcd_q <= '0;
		end else if (bcnt_q != '0) begin
			val_q <= val_q << 1;
			bcd_q <= {adj[NDEC*4-2:0], val_q[VALUE_WIDTH-1]};
		end
	end

	assign stat.busy = (bcnt_q != '0) | done_q;
	assign stat.done = done_q;
	assign bcd = bcd_q;

endmodule

FILE: hw/rtl/uafmt_emit.sv
// ----------------------------------------------------------------------------
// uafmt_emit
// Digit shift register: sends one digit per cycle MSB first as ASCII,
// dropping leading zeros and flagging the final digit.
// ----------------------------------------------------------------------------
module uafmt_emit
	import uafmt_pkg::*;
#(
	parameter int NDIG = 10
) (
	input  logic clk,
	input  logic arst_n,
	input  logic load,
	input  logic [NDIG*4-1:0] load_digits,
	input  logic [$clog2(NDIG+1)-1:0] load_cnt,
	output logic busy,
	output logic strobe,
	output uafmt_res_t result
);

	localparam int CW = $clog2(NDIG + 1);

	logic [NDIG*4-1:0] dig_q;
	logic [CW-1:0] cnt_q;
	logic seen_q;
	logic strobe_q;
	uafmt_res_t res_q;
	logic [3:0] d;
	logic is_last;
	logic show;

	assign d = dig_q[NDIG*4-1 -: 4];
	assign is_last = (cnt_q == CW'(1));
	assign show = (cnt_q != '0) && ((d != 4'd0) || seen_q || is_last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			seen_q <= 1'b0;
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= show;
			if (load) begin
				cnt_q <= load_cnt;
				seen_q <= 1'b0;
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - CW'(1);
				seen_q <= seen_q | (d != 4'd0);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			dig_q <= load_digits;
		end else if (cnt_q != '0) begin
			dig_q <= dig_q << 4;
		end
		res_q.ascii_char <= uafmt_glyph(d);
		res_q.last <= is_last;
	end

	assign busy = (cnt_q != '0);
	assign strobe = strobe_q;
	assign result = res_q;

endmodule
